>>> rtl/fsps_pkg.sv
// shared types and constants for the falling sand particle step core
// grid geometry, material and cell codes, item payload structs; no dependencies
package fsps_pkg;

  localparam int GRID_W     = 480;
  localparam int GRID_H     = 270;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int CX_W       = $clog2(GRID_W);
  localparam int CY_W       = $clog2(GRID_H);
  localparam int POS_W      = 16;
  localparam int CELL_W     = POS_W - 2;
  localparam int CODE_W     = 3;

  localparam logic [2:0] MAT_SAND  = 3'd0;
  localparam logic [2:0] MAT_WATER = 3'd1;
  localparam logic [2:0] MAT_WOOD  = 3'd2;
  localparam logic [2:0] MAT_LAVA  = 3'd3;
  localparam logic [2:0] MAT_SMOKE = 3'd4;

  localparam logic [CODE_W-1:0] CELL_EMPTY = 3'd0;
  localparam logic [CODE_W-1:0] CELL_SAND  = 3'd1;
  localparam logic [CODE_W-1:0] CELL_WATER = 3'd2;
  localparam logic [CODE_W-1:0] CELL_LAVA  = 3'd3;
  localparam logic [CODE_W-1:0] CELL_WOOD  = 3'd4;

  typedef struct packed {
    logic [2:0]              material;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    live;
  } fsps_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic                    survives;
  } fsps_out_t;

endpackage

>>> rtl/fsps_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module fsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/falling_sand_particle_step_core.sv
// top level of the falling sand particle step core: sequencer around the cell grid
// uses fsps_pkg and one fsps_ram instance holding the grid codes
//
// After reset the block holds busy high while it sweeps the grid memory to
// empty, one cell a cycle. An item is taken when start is high and busy is
// low; its result shows up on result for exactly one cycle with done high
// and cannot be held off. Each item is handled on its own: a particle that
// needs no grid access (smoke, dead fluid or wood, outside the grid, unknown
// material) raises done in the cycle right after the one in which it is
// taken. Otherwise every neighbour probe passes an address state (S_READ),
// then a wait state for the registered read data from the single grid
// memory (S_WAIT); a neighbour outside the grid skips the read and its wait
// state, and a move adds a write of the old cell (S_WR_SRC), then of the new
// cell (S_WR_DST). busy falls in the cycle done rises, so the next item may
// be taken while a result is out.
module falling_sand_particle_step_core
  import fsps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  fsps_in_t  particle,
  output logic      busy,
  output logic      done,
  output fsps_out_t result
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_WR_SRC = 3'd4;
  localparam logic [2:0] S_WR_DST = 3'd5;

  typedef logic signed [CELL_W:0] ncoord_t;

  function automatic logic signed [1:0] off_dx(input logic [2:0] mat, input logic [2:0] k);
    logic signed [1:0] d;
    d = 2'sd0;
    if (mat != MAT_WOOD) begin
      case (k)
        3'd1, 3'd3: d = 2'sd1;
        3'd2, 3'd4: d = -2'sd1;
        default:    d = 2'sd0;
      endcase
    end
    return d;
  endfunction

  function automatic logic signed [1:0] off_dy(input logic [2:0] mat, input logic [2:0] k);
    logic signed [1:0] d;
    if (mat == MAT_WOOD) begin
      d = (k == 3'd0) ? 2'sd0 : -2'sd1;
    end else begin
      d = (k inside {3'd0, 3'd1, 3'd2}) ? 2'sd1 : 2'sd0;
    end
    return d;
  endfunction

  function automatic logic [2:0] last_probe(input logic [2:0] mat);
    logic [2:0] n;
    case (mat)
      MAT_SAND: n = 3'd2;
      MAT_WOOD: n = 3'd1;
      default:  n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic in_grid(input ncoord_t x, input ncoord_t y);
    return (x >= 0) && (x < ncoord_t'(GRID_W)) && (y >= 0) && (y < ncoord_t'(GRID_H));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input ncoord_t x, input ncoord_t y);
    logic [CX_W-1:0] ux;
    logic [CY_W-1:0] uy;
    ux = x[CX_W-1:0];
    uy = y[CY_W-1:0];
    return ADDR_W'(ADDR_W'(ux) * ADDR_W'(GRID_H)) + ADDR_W'(uy);
  endfunction

  // pixel to cell, truncating toward zero
  function automatic logic signed [CELL_W-1:0] to_cell(input logic signed [POS_W-1:0] p);
    logic signed [POS_W-1:0] q;
    q = p + ((p < 0) ? POS_W'(3) : POS_W'(0));
    return q[POS_W-1:2];
  endfunction

  logic [2:0]               state, state_next;
  logic [ADDR_W-1:0]        clr_addr, clr_addr_next;
  logic [2:0]               mat, mat_next;
  logic signed [POS_W-1:0]  px, px_next, py, py_next;
  logic                     surv, surv_next;
  logic signed [CELL_W-1:0] cx, cx_next, cy, cy_next;
  logic [2:0]               k, k_next;
  logic [ADDR_W-1:0]        tgt_addr, tgt_addr_next;
  logic signed [1:0]        dx, dx_next, dy, dy_next;
  logic                     done_next;
  fsps_out_t                result_next;

  logic                     we, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [CODE_W-1:0]        wr_data, rd_data;

  logic signed [CELL_W-1:0] in_cx, in_cy;
  logic                     in_inside, needs_grid, hit;
  logic signed [1:0]        odx, ody;
  ncoord_t                  nx, ny;
  logic signed [POS_W-1:0]  smoke_y;
  logic                     smoke_surv;

  fsps_ram #(
    .WIDTH(CODE_W),
    .DEPTH(GRID_CELLS)
  ) u_grid (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    in_cx      = to_cell(particle.pos_x);
    in_cy      = to_cell(particle.pos_y);
    in_inside  = in_grid(ncoord_t'(in_cx), ncoord_t'(in_cy));
    needs_grid = in_inside && ((particle.material == MAT_SAND) ||
                 (particle.live && (particle.material == MAT_WATER ||
                  particle.material == MAT_WOOD || particle.material == MAT_LAVA)));
    smoke_y    = particle.pos_y;
    smoke_surv = particle.live;
    if (particle.material == MAT_SMOKE && particle.live) begin
      if (particle.pos_y > 0) begin
        smoke_y = particle.pos_y - POS_W'(4);
      end else begin
        smoke_surv = 1'b0;
      end
    end

    odx = off_dx(mat, k);
    ody = off_dy(mat, k);
    nx  = ncoord_t'(cx) + ncoord_t'(odx);
    ny  = ncoord_t'(cy) + ncoord_t'(ody);

    // sand sinks through water; wood burns only under lava
    if (mat == MAT_SAND && k == 3'd0) begin
      hit = (rd_data == CELL_EMPTY) || (rd_data == CELL_WATER);
    end else if (mat == MAT_WOOD && k == 3'd1) begin
      hit = (rd_data == CELL_LAVA);
    end else begin
      hit = (rd_data == CELL_EMPTY);
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    mat_next      = mat;
    px_next       = px;
    py_next       = py;
    surv_next     = surv;
    cx_next       = cx;
    cy_next       = cy;
    k_next        = k;
    tgt_addr_next = tgt_addr;
    dx_next       = dx;
    dy_next       = dy;
    done_next     = 1'b0;
    result_next   = result;
    we            = 1'b0;
    wr_addr       = clr_addr;
    wr_data       = CELL_EMPTY;
    rd_en         = 1'b0;
    rd_addr       = cell_addr(nx, ny);

    case (state)
      S_CLEAR: begin
        we            = 1'b1;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(GRID_CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mat_next  = particle.material;
          px_next   = particle.pos_x;
          py_next   = particle.pos_y;
          surv_next = particle.live;
          cx_next   = in_cx;
          cy_next   = in_cy;
          k_next    = 3'd0;
          if (needs_grid) begin
            state_next = S_READ;
          end else begin
            done_next   = 1'b1;
            result_next = '{new_x: particle.pos_x, new_y: smoke_y, survives: smoke_surv};
          end
        end
      end
      S_READ: begin
        if (in_grid(nx, ny)) begin
          rd_en         = 1'b1;
          tgt_addr_next = rd_addr;
          dx_next       = odx;
          dy_next       = ody;
          state_next    = S_WAIT;
        end else if (k == last_probe(mat)) begin
          done_next   = 1'b1;
          result_next = '{new_x: px, new_y: py, survives: surv};
          state_next  = S_IDLE;
        end else begin
          k_next = k + 3'd1;
        end
      end
      S_WAIT: begin
        if (hit) begin
          if (mat == MAT_WOOD && k == 3'd0) begin
            state_next = S_WR_DST;
          end else begin
            state_next = S_WR_SRC;
          end
        end else if (k == last_probe(mat)) begin
          done_next   = 1'b1;
          result_next = '{new_x: px, new_y: py, survives: surv};
          state_next  = S_IDLE;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_READ;
        end
      end
      S_WR_SRC: begin
        we      = 1'b1;
        wr_addr = cell_addr(ncoord_t'(cx), ncoord_t'(cy));
        wr_data = CELL_EMPTY;
        if (mat == MAT_WOOD) begin
          // burnt wood
          done_next   = 1'b1;
          result_next = '{new_x: px, new_y: py, survives: 1'b0};
          state_next  = S_IDLE;
        end else begin
          state_next = S_WR_DST;
        end
      end
      S_WR_DST: begin
        we      = 1'b1;
        wr_addr = tgt_addr;
        case (mat)
          MAT_SAND:  wr_data = CELL_SAND;
          MAT_WATER: wr_data = CELL_WATER;
          MAT_LAVA:  wr_data = CELL_LAVA;
          default:   wr_data = CELL_WOOD;
        endcase
        done_next   = 1'b1;
        result_next = '{new_x: px + {{(POS_W-4){dx[1]}}, dx, 2'b00},
                        new_y: py + {{(POS_W-4){dy[1]}}, dy, 2'b00},
                        survives: surv};
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
    mat      <= mat_next;
    px       <= px_next;
    py       <= py_next;
    surv     <= surv_next;
    cx       <= cx_next;
    cy       <= cy_next;
    k        <= k_next;
    tgt_addr <= tgt_addr_next;
    dx       <= dx_next;
    dy       <= dy_next;
    result   <= result_next;
  end

  // an accepted item either starts grid work or finishes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor finished");

  a_read_then_wait: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_WAIT))
    else $error("grid read not followed by wait state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("grid written while idle");

  a_no_read_write: assert property (@(posedge clk) disable iff (rst)
    !(we && rd_en))
    else $error("grid read and written in the same cycle");

endmodule
